/* src/dmm_pkg.sv */
// ---------------------------------------------------------------------------
// dmm_pkg
// shared constants, op codes, command/status types and helpers for the
// dense matrix multiply core
// ---------------------------------------------------------------------------
package dmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;

  // fixed field widths
  localparam int IDX_BITS     = 3;
  localparam int VAL_BITS     = 16;
  localparam int ACC_W        = 40;
  localparam int DIM_BITS     = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int OP_BITS      = 2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(8);

  // item op codes
  localparam logic [OP_BITS-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_BITS-1:0] OP_START  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_COLS    = 2'd2;

  typedef struct packed {
    logic                wr_a;
    logic                wr_b;
    logic                issue;      // read one term of the dot product
    logic                first;
    logic                last_term;
    logic                xfer;       // move finished sum into output register
    logic                xfer_last;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [IDX_BITS-1:0] k;
  } dmm_cmd_t;

  typedef struct packed {
    logic acc_ready;
    logic out_free;
  } dmm_status_t;

  // last index of a dimension after clamping to 1..max_dim
  function automatic logic [IDX_BITS-1:0] dim_last(input logic [DIM_BITS-1:0] v,
                                                   input int unsigned max_dim);
    logic [IDX_BITS-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (32'(v) > max_dim) begin
      res = IDX_BITS'(max_dim - 1);
    end else begin
      res = IDX_BITS'(v - DIM_BITS'(1));
    end
    return res;
  endfunction

endpackage

/* src/dense_matrix_multiply_core.sv */
// ---------------------------------------------------------------------------
// dense_matrix_multiply_core
// fixed-point c = a x b: load beats fill the a and b stores, a start beat
// streams out every c element in row-major order, last one marked by tlast
// ---------------------------------------------------------------------------
// an in-range load beat writes its store as it is accepted; loads are accepted back to back while idle
// after a start beat, tvalid rises for the first result once its terms have passed the read and multiply registers
// and the accumulator, and its sum has moved into the output register; each result is summed term by term on the single
// multiply-accumulate unit (one store read per term, then read, multiply, accumulate) and waits until the output
// register is free before the next one starts; tready is low during a run
// reset: synchronous, dimension registers return to 8, stores hold no reset
module dense_matrix_multiply_core #(
  parameter int MAX_DIM   = dmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = dmm_pkg::ELEM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [23:0]                           s_axis_tdata,  // row_index, col_index, elem_value
  input  logic [dmm_pkg::OP_BITS-1:0]           s_axis_tuser,  // command
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [47:0]                           m_axis_tdata,  // out_row, out_col, out_value
  output logic                                  m_axis_tlast,  // last_flag
  input  logic                                  cfg_we,
  input  logic [dmm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [dmm_pkg::DIM_BITS-1:0]          cfg_data
);

  import dmm_pkg::*;

  logic [DIM_BITS-1:0]      a_rows;
  logic [DIM_BITS-1:0]      inner_len;
  logic [DIM_BITS-1:0]      b_cols;
  logic [IDX_BITS-1:0]      nr_last;
  logic [IDX_BITS-1:0]      nk_last;
  logic [IDX_BITS-1:0]      nc_last;
  logic [IDX_BITS-1:0]      in_row;
  logic [IDX_BITS-1:0]      in_col;
  logic signed [VAL_BITS-1:0] in_value;
  logic [IDX_BITS-1:0]      out_row;
  logic [IDX_BITS-1:0]      out_col;
  logic [ACC_W-1:0]         out_value;
  dmm_cmd_t                 cmd;
  dmm_status_t              status;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= DIM_RESET;
      inner_len <= DIM_RESET;
      b_cols    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS:    a_rows    <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        REG_B_COLS:    b_cols    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, anything past the store size as the store size
  assign nr_last = dim_last(a_rows, MAX_DIM);
  assign nk_last = dim_last(inner_len, MAX_DIM);
  assign nc_last = dim_last(b_cols, MAX_DIM);

  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[5:3];
  assign in_value = $signed(s_axis_tdata[21:6]);

  dmm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_row   (in_row),
    .in_col   (in_col),
    .nr_last  (nr_last),
    .nk_last  (nk_last),
    .nc_last  (nc_last),
    .status   (status),
    .cmd      (cmd)
  );

  dmm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .out_ready (m_axis_tready),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

/* src/dmm_ram.sv */
// ---------------------------------------------------------------------------
// dmm_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/dmm_ctrl.sv */
// ---------------------------------------------------------------------------
// dmm_ctrl
// sequencer: takes load and start beats, walks row, column and inner index
// and hands finished sums to the output register
// ---------------------------------------------------------------------------
module dmm_ctrl #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dmm_pkg::OP_BITS-1:0]        in_op,
  input  logic [dmm_pkg::IDX_BITS-1:0]       in_row,
  input  logic [dmm_pkg::IDX_BITS-1:0]       in_col,
  input  logic [dmm_pkg::IDX_BITS-1:0]       nr_last,
  input  logic [dmm_pkg::IDX_BITS-1:0]       nk_last,
  input  logic [dmm_pkg::IDX_BITS-1:0]       nc_last,
  input  dmm_pkg::dmm_status_t               status,
  output dmm_pkg::dmm_cmd_t                  cmd
);

  import dmm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t              state;
  logic [IDX_BITS-1:0] r;
  logic [IDX_BITS-1:0] c;
  logic [IDX_BITS-1:0] k;
  logic                in_range;
  logic                accept;
  logic                run_end;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = ((IDX_BITS+1)'(in_row) < (IDX_BITS+1)'(MAX_DIM)) &&
                    ((IDX_BITS+1)'(in_col) < (IDX_BITS+1)'(MAX_DIM));
  assign run_end  = (r == nr_last) && (c == nc_last);

  always_comb begin
    cmd           = '0;
    cmd.row       = r;
    cmd.col       = c;
    cmd.k         = k;
    cmd.wr_a      = accept && (in_op == OP_LOAD_A) && in_range;
    cmd.wr_b      = accept && (in_op == OP_LOAD_B) && in_range;
    cmd.issue     = (state == ST_RUN);
    cmd.first     = (k == '0);
    cmd.last_term = (k == nk_last);
    cmd.xfer      = (state == ST_DRAIN) && status.acc_ready && status.out_free;
    cmd.xfer_last = run_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (in_op == OP_START)) begin
            r     <= '0;
            c     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k == nk_last) begin
            k     <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + IDX_BITS'(1);
          end
        end
        ST_DRAIN: begin
          if (status.acc_ready && status.out_free) begin
            if (run_end) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RUN;
              if (c == nc_last) begin
                c <= '0;
                r <= r + IDX_BITS'(1);
              end else begin
                c <= c + IDX_BITS'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/dmm_datapath.sv */
// ---------------------------------------------------------------------------
// dmm_datapath
// element stores, one multiply-accumulate unit and the output register
// ---------------------------------------------------------------------------
module dmm_datapath #(
  parameter int MAX_DIM   = dmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = dmm_pkg::ELEM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dmm_pkg::dmm_cmd_t                   cmd,
  input  logic [dmm_pkg::IDX_BITS-1:0]        in_row,
  input  logic [dmm_pkg::IDX_BITS-1:0]        in_col,
  input  logic signed [dmm_pkg::VAL_BITS-1:0] in_value,
  input  logic                                out_ready,
  output dmm_pkg::dmm_status_t                status,
  output logic                                out_valid,
  output logic [dmm_pkg::IDX_BITS-1:0]        out_row,
  output logic [dmm_pkg::IDX_BITS-1:0]        out_col,
  output logic [dmm_pkg::ACC_W-1:0]           out_value,
  output logic                                out_last
);

  import dmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ADDR_W-1:0]            wr_addr;
  logic [ADDR_W-1:0]            a_raddr;
  logic [ADDR_W-1:0]            b_raddr;
  logic signed [ELEM_BITS-1:0]  wr_elem;
  logic [ELEM_BITS-1:0]         a_rd;
  logic [ELEM_BITS-1:0]         b_rd;
  logic                         v1;
  logic                         first1;
  logic                         last1;
  logic                         v2;
  logic                         first2;
  logic                         last2;
  logic signed [2*ELEM_BITS-1:0] prod;
  logic [ACC_W-1:0]             acc;
  logic                         acc_ready;

  assign wr_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col));
  assign a_raddr = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k));
  assign b_raddr = ADDR_W'(ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col));
  // sign extends or cuts the q8.8 value to the element width
  assign wr_elem = ELEM_BITS'(in_value);

  dmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .re    (cmd.issue),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  dmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .re    (cmd.issue),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  assign status.acc_ready = acc_ready;
  assign status.out_free  = !out_valid || out_ready;

  // read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      acc_ready <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (v2 && last2) begin
        acc_ready <= 1'b1;
      end else if (cmd.xfer) begin
        acc_ready <= 1'b0;
      end
    end
    first1 <= cmd.first;
    last1  <= cmd.last_term;
    first2 <= first1;
    last2  <= last1;
    prod   <= $signed(a_rd) * $signed(b_rd);
    if (v2) begin
      // sum wraps at the accumulator width
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.xfer) begin
      out_row   <= cmd.row;
      out_col   <= cmd.col;
      out_value <= acc;
      out_last  <= cmd.xfer_last;
    end
  end

  a_xfer_needs_sum : assert property (@(posedge clk) disable iff (rst)
    cmd.xfer |-> acc_ready)
    else $error("result moved out before its sum was complete");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.xfer)
    else $error("output register overwritten while held");

  a_no_term_on_held_sum : assert property (@(posedge clk) disable iff (rst)
    v2 |-> !acc_ready)
    else $error("new term accumulated over an unsent sum");

endmodule
